// ===== rtl/esc_pkg.sv =====
`timescale 1ns / 1ps
package esc_pkg;

  localparam int unsigned DIV_DEPTH = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 64;

  localparam logic [31:0] T_OFFSET    = 32'd64000;
  localparam logic [31:0] H_OFFSET    = 32'd76800;
  localparam logic [31:0] P_SCALE     = 32'd3125;
  localparam logic [31:0] P_FULL      = 32'd1048576;
  localparam logic [31:0] P_HALF      = 32'h8000_0000;
  localparam logic [31:0] H_LIMIT     = 32'd419430400;
  localparam logic [31:0] H_BIAS      = 32'd2097152;
  localparam logic [31:0] H_ROUND_A   = 32'd16384;
  localparam logic [31:0] P_UNITY     = 32'd32768;
  localparam logic [31:0] H_ROUND_B   = 32'd8192;
  localparam logic [31:0] T_ROUND     = 32'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP    = 3'd0,
    REG_PRESS_A = 3'd1,
    REG_PRESS_B = 3'd2,
    REG_PRESS_C = 3'd3,
    REG_HUM     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic [31:0]        pressure;
    logic [16:0]        humidity;
    logic               press_invalid;
  } result_t;

  // Coefficients widened to 32-bit two's complement patterns
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } cal_t;

  typedef struct packed {
    logic [31:0] temperature;
    logic [16:0] humidity;
    logic        press_invalid;
    logic        dbl;
  } side_t;

  typedef struct packed {
    logic [31:0] dividend;
    logic [31:0] divisor;
    side_t       side;
  } div_req_t;

  typedef struct packed {
    logic [31:0] quotient;
    side_t       side;
  } div_rsp_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] r;
    r = 64'(a) * 64'(b);
    return r[31:0];
  endfunction

endpackage

// ===== rtl/esc_front.sv =====
`timescale 1ns / 1ps
module esc_front
  import esc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     take,
  input  sample_t  sample,
  input  cal_t     cal,
  output logic     req_valid,
  output div_req_t req
);

  localparam int unsigned DEPTH = 13;

  logic [DEPTH-1:0] v;

  logic [31:0] at1, dd1, ap1, ah1;
  logic [31:0] a11_2, x2, ap2, ah2;
  logic [31:0] fine3, ap3, ah3;
  logic [31:0] temp4, pa4, sq4, dh4, ap4, ah4;
  logic [31:0] m6_5, m5_5, m3_5, m2_5, hm5_5, hm6_5, hm3_5, hbase5, temp5, ap5;
  logic [31:0] pb6, paa6, ha6, hb1_6, hc6, temp6, ap6;
  logic [31:0] den7, pp7, hb2_7, ha7, temp7;
  logic [31:0] hm8, ha8, hb4_9, ha9, hd10, hsq11, hd11, hm1_12, hd12;
  div_req_t    pr8, pr9, pr10, pr11, pr12;

  logic [31:0] dt, hd2, hclamp;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DEPTH-2:0], take};
    end
  end

  assign dt = 32'(sample.raw_temp >> 4) - cal.t1;

  // Temperature, fine value and the offsets from it for pressure and humidity
  always_ff @(posedge clk) begin
    if (en) begin
      at1   <= mul(32'(sample.raw_temp >> 3) - (cal.t1 << 1), cal.t2);
      dd1   <= mul(dt, dt);
      ap1   <= 32'(sample.raw_press);
      ah1   <= 32'(sample.raw_hum);
      a11_2 <= asr(at1, 5'd11);
      x2    <= mul(asr(dd1, 5'd12), cal.t3);
      ap2   <= ap1;
      ah2   <= ah1;
      fine3 <= a11_2 + asr(x2, 5'd14);
      ap3   <= ap2;
      ah3   <= ah2;
      temp4 <= asr((fine3 << 2) + fine3 + T_ROUND, 5'd8);
      pa4   <= asr(fine3, 5'd1) - T_OFFSET;
      sq4   <= mul(asr(asr(fine3, 5'd1) - T_OFFSET, 5'd2),
                   asr(asr(fine3, 5'd1) - T_OFFSET, 5'd2));
      dh4   <= fine3 - H_OFFSET;
      ap4   <= ap3;
      ah4   <= ah3;
    end
  end

  // Pressure divisor and dividend, humidity front half
  always_ff @(posedge clk) begin
    if (en) begin
      m6_5   <= mul(asr(sq4, 5'd11), cal.p6);
      m5_5   <= mul(pa4, cal.p5);
      m3_5   <= mul(cal.p3, asr(sq4, 5'd13));
      m2_5   <= mul(cal.p2, pa4);
      hm5_5  <= mul(cal.h5, dh4);
      hm6_5  <= mul(dh4, cal.h6);
      hm3_5  <= mul(dh4, cal.h3);
      hbase5 <= (ah4 << 14) - (cal.h4 << 20);
      temp5  <= temp4;
      ap5    <= ap4;

      pb6    <= asr(m6_5 + (m5_5 << 1), 5'd2) + (cal.p4 << 16);
      paa6   <= asr(asr(m3_5, 5'd3) + asr(m2_5, 5'd1), 5'd18);
      ha6    <= asr(hbase5 - hm5_5 + H_ROUND_A, 5'd15);
      hb1_6  <= asr(hm6_5, 5'd10);
      hc6    <= asr(hm3_5, 5'd11) + P_UNITY;
      temp6  <= temp5;
      ap6    <= ap5;

      den7   <= mul(P_UNITY + paa6, cal.p1) >> 15;
      pp7    <= mul((P_FULL - ap6) - asr(pb6, 5'd12), P_SCALE);
      hb2_7  <= mul(hb1_6, hc6);
      ha7    <= ha6;
      temp7  <= temp6;
    end
  end

  // Pick the division branch; carry the request while humidity finishes
  always_ff @(posedge clk) begin
    if (en) begin
      pr8.divisor            <= den7;
      pr8.dividend           <= (pp7 < P_HALF) ? (pp7 << 1) : pp7;
      pr8.side.dbl           <= (pp7 >= P_HALF);
      pr8.side.press_invalid <= (den7 == '0);
      pr8.side.temperature   <= temp7;
      pr8.side.humidity      <= '0;
      hm8    <= mul(asr(hb2_7, 5'd10) + H_BIAS, cal.h2);
      ha8    <= ha7;
      pr9    <= pr8;
      hb4_9  <= asr(hm8 + H_ROUND_B, 5'd14);
      ha9    <= ha8;
      pr10   <= pr9;
      hd10   <= mul(ha9, hb4_9);
      pr11   <= pr10;
      hsq11  <= mul(asr(hd10, 5'd15), asr(hd10, 5'd15));
      hd11   <= hd10;
      pr12   <= pr11;
      hm1_12 <= mul(asr(hsq11, 5'd7), cal.h1);
      hd12   <= hd11;
    end
  end

  // Clamp humidity to 0..100 %RH
  always_comb begin
    hd2 = hd12 - asr(hm1_12, 5'd4);
    if (hd2[31]) begin
      hclamp = '0;
    end else if (hd2 > H_LIMIT) begin
      hclamp = H_LIMIT;
    end else begin
      hclamp = hd2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req.dividend           <= pr12.dividend;
      req.divisor            <= pr12.divisor;
      req.side.temperature   <= pr12.side.temperature;
      req.side.humidity      <= hclamp[28:12];
      req.side.press_invalid <= pr12.side.press_invalid;
      req.side.dbl           <= pr12.side.dbl;
    end
  end

  assign req_valid = v[DEPTH-1];

endmodule

// ===== rtl/esc_div.sv =====
`timescale 1ns / 1ps
module esc_div
  import esc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     req_valid,
  input  div_req_t req,
  output logic     rsp_valid,
  output div_rsp_t rsp
);

  logic [DIV_DEPTH-1:0] v;
  logic [31:0]          rem_q [DIV_DEPTH];
  logic [31:0]          num_q [DIV_DEPTH];
  logic [31:0]          quo_q [DIV_DEPTH];
  logic [31:0]          den_q [DIV_DEPTH];
  side_t                side_q[DIV_DEPTH];

  // One restoring step per stage, most significant quotient bit first
  for (genvar i = 0; i < DIV_DEPTH; i++) begin : g_step
    logic [31:0] rem_p, num_p, quo_p, den_p;
    side_t       side_p;
    logic        v_p;
    logic [32:0] trial;
    logic        ge;

    if (i == 0) begin : g_head
      assign rem_p  = '0;
      assign num_p  = req.dividend;
      assign quo_p  = '0;
      assign den_p  = req.divisor;
      assign side_p = req.side;
      assign v_p    = req_valid;
    end else begin : g_body
      assign rem_p  = rem_q[i-1];
      assign num_p  = num_q[i-1];
      assign quo_p  = quo_q[i-1];
      assign den_p  = den_q[i-1];
      assign side_p = side_q[i-1];
      assign v_p    = v[i-1];
    end

    assign trial = {rem_p, num_p[31]};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? 32'(trial - {1'b0, den_p}) : trial[31:0];
        num_q[i]  <= num_p << 1;
        quo_q[i]  <= {quo_p[30:0], ge};
        den_q[i]  <= den_p;
        side_q[i] <= side_p;
      end
    end
  end

  assign rsp_valid    = v[DIV_DEPTH-1];
  assign rsp.quotient = quo_q[DIV_DEPTH-1];
  assign rsp.side     = side_q[DIV_DEPTH-1];

endmodule

// ===== rtl/esc_back.sv =====
`timescale 1ns / 1ps
module esc_back
  import esc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     rsp_valid,
  input  div_rsp_t rsp,
  input  cal_t     cal,
  output logic     res_valid,
  output result_t  res
);

  logic [2:0]  v;
  logic [31:0] p0, p1q, p2q, m9a1, m8_1, m9_2, m8s2;
  side_t       s1, s2;
  logic [31:0] p_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], rsp_valid};
    end
  end

  // Undo the halved branch
  assign p0 = rsp.side.dbl ? (rsp.quotient << 1) : rsp.quotient;

  // Second-order pressure trim
  always_ff @(posedge clk) begin
    if (en) begin
      p1q  <= p0;
      m9a1 <= mul(p0 >> 3, p0 >> 3);
      m8_1 <= mul(p0 >> 2, cal.p8);
      s1   <= rsp.side;
      p2q  <= p1q;
      m9_2 <= mul(cal.p9, m9a1 >> 13);
      m8s2 <= asr(m8_1, 5'd13);
      s2   <= s1;
    end
  end

  assign p_fin = p2q + asr(asr(m9_2, 5'd12) + m8s2 + cal.p7, 5'd4);

  // Result register
  always_ff @(posedge clk) begin
    if (en) begin
      res.temperature   <= $signed(s2.temperature);
      res.pressure      <= s2.press_invalid ? '0 : p_fin;
      res.humidity      <= s2.humidity;
      res.press_invalid <= s2.press_invalid;
    end
  end

  assign res_valid = v[2];

endmodule

// ===== rtl/env_sensor_compensation.sv =====
`timescale 1ns / 1ps
// Integer compensation of a pressure/humidity sensor: each transfer on the
// input carries one raw temperature, pressure and humidity sample set and
// yields one transfer on the output with temperature in 0.01 degC, pressure
// in Pa (zero with press_invalid set when the divisor is zero) and humidity
// in Q7.10 %RH. One sample set is taken every cycle when not stalled; the
// pipeline has 13 stages of trim arithmetic, 32 stages of the pipelined
// pressure divider (one quotient bit per stage) and 3 stages of final trim
// and the output register. A stall on a valid output holds the whole
// pipeline. Coefficients are written through cfg_we/cfg_index/cfg_data and
// must only change while the pipeline is empty.
module env_sensor_compensation
  import esc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sample_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output result_t              out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [47:0] temp_coeffs, press_a, press_b, press_c;
  logic [63:0] hum_coeffs;
  cal_t        cal;
  logic        en, req_valid, rsp_valid;
  div_req_t    req;
  div_rsp_t    rsp;

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_a     <= '0;
      press_b     <= '0;
      press_c     <= '0;
      hum_coeffs  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP:    temp_coeffs <= cfg_data[47:0];
        REG_PRESS_A: press_a     <= cfg_data[47:0];
        REG_PRESS_B: press_b     <= cfg_data[47:0];
        REG_PRESS_C: press_c     <= cfg_data[47:0];
        REG_HUM:     hum_coeffs  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the trim fields, sign-extending all but t1, p1, h1 and h3
  always_comb begin
    cal.t1 = 32'(temp_coeffs[15:0]);
    cal.t2 = 32'($signed(temp_coeffs[31:16]));
    cal.t3 = 32'($signed(temp_coeffs[47:32]));
    cal.p1 = 32'(press_a[15:0]);
    cal.p2 = 32'($signed(press_a[31:16]));
    cal.p3 = 32'($signed(press_a[47:32]));
    cal.p4 = 32'($signed(press_b[15:0]));
    cal.p5 = 32'($signed(press_b[31:16]));
    cal.p6 = 32'($signed(press_b[47:32]));
    cal.p7 = 32'($signed(press_c[15:0]));
    cal.p8 = 32'($signed(press_c[31:16]));
    cal.p9 = 32'($signed(press_c[47:32]));
    cal.h1 = 32'(hum_coeffs[7:0]);
    cal.h2 = 32'($signed(hum_coeffs[23:8]));
    cal.h3 = 32'(hum_coeffs[31:24]);
    cal.h4 = 32'($signed(hum_coeffs[43:32]));
    cal.h5 = 32'($signed(hum_coeffs[55:44]));
    cal.h6 = 32'($signed(hum_coeffs[63:56]));
  end

  // Hold every stage while a finished result waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  esc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .take      (in_valid),
    .sample    (in_data),
    .cal       (cal),
    .req_valid (req_valid),
    .req       (req)
  );

  esc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  esc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cal       (cal),
    .res_valid (out_valid),
    .res       (out_data)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import esc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] NO_REG = 3'd7;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned N_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 230;

  // Scoreboard: holds its own copy of the coefficients and predicts each result
  class comp_scoreboard;
    logic [63:0] cal [5];
    result_t     expected_q [$];
    int          errors;
    int          checked;
    int          invalid_seen;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      if (idx <= REG_PRESS_C) cal[idx] = {16'd0, data[47:0]};
      else if (idx == REG_HUM) cal[idx] = data;
    endfunction

    function logic [31:0] sra(logic [31:0] x, int n);
      return $unsigned($signed(x) >>> n);
    endfunction

    function logic [31:0] wmul(logic [31:0] a, logic [31:0] b);
      logic [63:0] r;
      r = {32'd0, a} * {32'd0, b};
      return r[31:0];
    endfunction

    function logic [31:0] sx(logic [63:0] r, int pos, int w);
      logic [31:0] v;
      v = 32'(r >> pos) & ((32'd1 << w) - 32'd1);
      return (v ^ (32'd1 << (w - 1))) - (32'd1 << (w - 1));
    endfunction

    // Integer trim compensation of one sample set
    function result_t compensate(sample_t s);
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] h1, h2, h3, h4, h5, h6;
      logic [31:0] a, b, d, fine, pr;
      result_t r;
      t1 = {16'd0, cal[REG_TEMP][15:0]};
      t2 = sx(cal[REG_TEMP], 16, 16);
      t3 = sx(cal[REG_TEMP], 32, 16);
      p1 = {16'd0, cal[REG_PRESS_A][15:0]};
      p2 = sx(cal[REG_PRESS_A], 16, 16);
      p3 = sx(cal[REG_PRESS_A], 32, 16);
      p4 = sx(cal[REG_PRESS_B], 0, 16);
      p5 = sx(cal[REG_PRESS_B], 16, 16);
      p6 = sx(cal[REG_PRESS_B], 32, 16);
      p7 = sx(cal[REG_PRESS_C], 0, 16);
      p8 = sx(cal[REG_PRESS_C], 16, 16);
      p9 = sx(cal[REG_PRESS_C], 32, 16);
      h1 = {24'd0, cal[REG_HUM][7:0]};
      h2 = sx(cal[REG_HUM], 8, 16);
      h3 = {24'd0, cal[REG_HUM][31:24]};
      h4 = sx(cal[REG_HUM], 32, 12);
      h5 = sx(cal[REG_HUM], 44, 12);
      h6 = sx(cal[REG_HUM], 56, 8);
      // temperature and fine value
      a = sra(wmul(({12'd0, s.raw_temp} >> 3) - (t1 << 1), t2), 11);
      d = ({12'd0, s.raw_temp} >> 4) - t1;
      b = sra(wmul(sra(wmul(d, d), 12), t3), 14);
      fine = a + b;
      r.temperature = sra(wmul(fine, 32'd5) + 32'd128, 8);
      // pressure
      a = sra(fine, 1) - 32'd64000;
      d = sra(wmul(sra(a, 2), sra(a, 2)), 11);
      b = wmul(d, p6);
      b = b + (wmul(a, p5) << 1);
      b = sra(b, 2) + (p4 << 16);
      d = sra(wmul(sra(a, 2), sra(a, 2)), 13);
      a = sra(sra(wmul(p3, d), 3) + sra(wmul(p2, a), 1), 18);
      a = wmul(32'd32768 + a, p1) >> 15;
      r.press_invalid = (a == 32'd0);
      if (a == 32'd0) begin
        pr = 32'd0;
      end else begin
        pr = wmul((32'd1048576 - {12'd0, s.raw_press}) - sra(b, 12), 32'd3125);
        // large dividend: divide first, then double
        if (pr < 32'h8000_0000) pr = (pr << 1) / a;
        else pr = (pr / a) * 32'd2;
        a = sra(wmul(p9, wmul(pr >> 3, pr >> 3) >> 13), 12);
        b = sra(wmul(pr >> 2, p8), 13);
        pr = pr + sra(a + b + p7, 4);
      end
      r.pressure = pr;
      // humidity
      d = fine - 32'd76800;
      a = sra((({16'd0, s.raw_hum} << 14) - (h4 << 20) - wmul(h5, d)) + 32'd16384, 15);
      b = sra(wmul(d, h6), 10);
      b = wmul(b, sra(wmul(d, h3), 11) + 32'd32768);
      b = sra(b, 10) + 32'd2097152;
      b = sra(wmul(b, h2) + 32'd8192, 14);
      d = wmul(a, b);
      a = sra(wmul(sra(d, 15), sra(d, 15)), 7);
      d = d - sra(wmul(a, h1), 4);
      // clamp to 0..100 %RH
      if (d[31]) d = 32'd0;
      if (d > 32'd419430400) d = 32'd419430400;
      r.humidity = 17'(d >> 12);
      return r;
    endfunction

    function void note_sample(sample_t s);
      expected_q.push_back(compensate(s));
    endfunction

    function void check_result(result_t act);
      result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer %h", act);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (act.press_invalid) invalid_seen++;
      if (act.temperature !== e.temperature) begin
        $error("temperature exp %0d act %0d", e.temperature, act.temperature);
        errors++;
      end
      if (act.pressure !== e.pressure) begin
        $error("pressure exp %0d act %0d", e.pressure, act.pressure);
        errors++;
      end
      if (act.humidity !== e.humidity) begin
        $error("humidity exp %0d act %0d", e.humidity, act.humidity);
        errors++;
      end
      if (act.press_invalid !== e.press_invalid) begin
        $error("press_invalid exp %0b act %0b", e.press_invalid, act.press_invalid);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sample_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  result_t              out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  comp_scoreboard sb = new();

  env_sensor_compensation DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: stall at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic send_sample(sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
  endtask

  // Hold off until the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_cal(logic [63:0] vals [5]);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.write_reg(i[CFG_IDX_W-1:0], vals[i]);
    end
    // out-of-range index must be ignored
    cfg_index <= NO_REG;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    s.raw_temp  = 20'($urandom);
    s.raw_press = 20'($urandom);
    s.raw_hum   = 16'($urandom);
    case ($urandom_range(7))
      0: s.raw_press = 20'($urandom_range(4095));
      1: s.raw_temp  = 20'($urandom_range(400000, 600000));
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    logic [63:0] typical [5];
    logic [63:0] vals [5];
    sample_t     s;
    typical[REG_TEMP]    = {16'hFC18, 16'd26435, 16'd27504};
    typical[REG_PRESS_A] = {16'd3024, 16'hD643, 16'd36477};
    typical[REG_PRESS_B] = {16'hFFF9, 16'd140, 16'd2855};
    typical[REG_PRESS_C] = {16'd6000, 16'hC6F8, 16'd15500};
    typical[REG_HUM]     = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset coefficients (zero divisor), then typical trim with field extremes
    send_sample('0);
    send_sample('1);
    drain();
    load_cal(typical);
    send_sample('0);
    send_sample('1);
    send_sample({20'd519888, 20'd415148, 16'd30000});
    send_sample({20'd519888, 20'd0, 16'd0});
    send_sample({20'd519888, 20'hFFFFF, 16'hFFFF});
    send_sample({20'd0, 20'd1, 16'd1});
    send_sample({20'hFFFFF, 20'd0, 16'hFFFF});
    send_sample({20'h80000, 20'h80000, 16'h8000});
    send_sample({20'h7FFFF, 20'h7FFFF, 16'h7FFF});
    send_sample({20'd400000, 20'd300000, 16'd65535});
    send_sample({20'd600000, 20'd600000, 16'd0});
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      send_idle_pct = (ph < 3) ? 31 : (ph < 6) ? 73 : 0;
      recv_idle_pct = (ph < 3) ? 73 : (ph < 6) ? 31 : 0;
      case (ph)
        0: vals = typical;
        2: foreach (vals[i]) vals[i] = '1;
        3: foreach (vals[i]) vals[i] = '0;
        4: begin
          vals = typical;
          vals[REG_PRESS_A][15:0] = 16'd0;
        end
        5: foreach (vals[i]) vals[i] = typical[i] ^ 64'($urandom_range(255));
        7: foreach (vals[i]) vals[i] = 64'h8000_8000_8000_8000;
        default: foreach (vals[i]) vals[i] = {$urandom, $urandom};
      endcase
      load_cal(vals);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        s = rand_sample();
        send_sample(s);
      end
      drain();
    end

    $display("Covered %0d results over %0d trim settings, %0d with zero pressure divisor.",
             sb.checked, N_PHASES + 2, sb.invalid_seen);
    $display("Idle mixes: sender-heavy, receiver-heavy and none; pipeline drained per phase.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
